[rtl/assert_macros.svh]
// assertion macros shared by the queue, multiplier and back-end rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property with reset disable
`define PCA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds during reset
`define PCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pca_pkg.sv]
// types and constants of the correlation accumulator
`default_nettype none
package pca_pkg;
   localparam int MAX_TRACES = 65536;
   localparam int COUNT_W = 17;
   localparam int MUL_A_W = 160;
   localparam int MUL_B_W = 64;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int Q_W = 17;
   localparam int Q_ONE = 32768;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [23:0]        sum_model;
      logic signed [31:0] sum_trace;
      logic [31:0]        sum_model_sq;
      logic [46:0]        sum_trace_sq;
      logic signed [40:0] sum_cross;
   } sums_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_A_W-1:0] p;
   } mul_rsp_type;
endpackage
`default_nettype wire

[rtl/pca_front.sv]
// front end: accepts items and keeps count and running sums
`default_nettype none
module pca_front
   import pca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_trace_value,
   input  wire logic [7:0]  req_model_value,
   input  wire logic        req_restart,
   input  wire logic        req_checkpoint,
   input  wire logic        queue_full,
   output logic             push,
   output sums_type         push_data
);
   sums_type sums_ff, sums_in, base;
   logic accept;
   logic signed [15:0] x;
   logic [7:0] y;
   logic signed [31:0] xx;
   logic [15:0] yy;
   logic signed [24:0] xy;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;
   assign x = $signed(req_trace_value);
   assign y = req_model_value;
   assign xx = x * x;
   assign yy = y * y;
   assign xy = x * $signed({1'b0, y});

   always_comb begin
      base = req_restart ? '0 : sums_ff;
      sums_in = base;
      if (base.count < COUNT_W'(MAX_TRACES)) begin
         sums_in.count = base.count + 1'b1;
         sums_in.sum_trace = base.sum_trace + 32'(x);
         sums_in.sum_model = base.sum_model + 24'(y);
         sums_in.sum_trace_sq = base.sum_trace_sq + 47'($unsigned(xx));
         sums_in.sum_model_sq = base.sum_model_sq + 32'(yy);
         sums_in.sum_cross = base.sum_cross + 41'(xy);
      end
   end

   assign push = accept && req_checkpoint;
   assign push_data = sums_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else if (accept) begin
         sums_ff <= sums_in;
      end
   end
endmodule
`default_nettype wire

[rtl/pca_queue.sv]
// two-entry queue of checkpoint snapshots
`default_nettype none
module pca_queue
   import pca_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire sums_type push_data,
   input  wire logic     pop,
   output sums_type      head,
   output logic          full,
   output logic          empty
);
   `include "assert_macros.svh"

   sums_type mem [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] level_ff;

   assign full = (level_ff == 2'd2);
   assign empty = (level_ff == 2'd0);
   assign head = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         level_ff <= level_ff + 2'(push) - 2'(pop);
      end
   end

   `PCA_ASSERT(a_no_overflow, clock, reset, full |-> !push, "push into full queue")
   `PCA_ASSERT(a_no_underflow, clock, reset, empty |-> !pop, "pop from empty queue")
endmodule
`default_nettype wire

[rtl/pca_mul.sv]
// shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module pca_mul
   import pca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output mul_rsp_type      rsp
);
   `include "assert_macros.svh"

   logic [MUL_A_W-1:0] a_ff, acc_ff;
   logic [MUL_B_W-1:0] b_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff;

   assign rsp.done = done_ff;
   assign rsp.p = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff <= req.a;
         b_ff <= req.b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_ff <= acc_ff + a_ff;
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   `PCA_ASSERT(a_start_idle, clock, reset, req.start |-> !busy_ff, "multiply started while busy")
endmodule
`default_nettype wire

[rtl/pca_back.sv]
// back end: works out |r| for one snapshot and holds the result
`default_nettype none
module pca_back
   import pca_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sums_type      head,
   input  wire logic          empty,
   output logic               pop,
   output mul_req_type        mul_req,
   input  wire mul_rsp_type   mul_rsp,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [15:0]        rsp_abs_correlation,
   output logic               rsp_null_variance,
   output logic [COUNT_W-1:0] rsp_traces_used
);
   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_VX1, ST_VX2, ST_VY1, ST_VY2, ST_CV1, ST_CV2,
      ST_PROD, ST_LIM, ST_CAND, ST_CSQ, ST_TEST, ST_DONE
   } state_type;

   state_type state_ff, ret_ff;
   mul_req_type mul_req_ff;
   logic [63:0] t1_ff, vx_ff, vy_ff, cv_ff;
   logic [127:0] prod_ff;
   logic [MUL_A_W-1:0] lim_ff;
   logic [Q_W-1:0] q_ff, bit_ff, cand;
   logic null_ff;
   logic rsp_valid_ff;
   logic [15:0] abs_ff;
   logic nv_ff;
   logic [COUNT_W-1:0] used_ff;
   logic [31:0] mag_x;
   logic [40:0] mag_xy;
   logic [63:0] p64, vy_in;

   assign mag_x = head.sum_trace[31] ? 32'(-head.sum_trace) : 32'(head.sum_trace);
   assign mag_xy = head.sum_cross[40] ? 41'(-head.sum_cross) : 41'(head.sum_cross);
   assign p64 = mul_rsp.p[63:0];
   assign vy_in = (t1_ff >= p64) ? t1_ff - p64 : 64'd0;
   assign cand = q_ff | bit_ff;

   assign mul_req = mul_req_ff;
   assign pop = (state_ff == ST_DONE) && !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_abs_correlation = abs_ff;
   assign rsp_null_variance = nv_ff;
   assign rsp_traces_used = used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         mul_req_ff.start <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a stalled result holds, the done state loads a new one
         rsp_valid_ff <= (state_ff == ST_DONE) || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  mul_req_ff <= '{1'b1, MUL_A_W'(head.sum_trace_sq), MUL_B_W'(head.count)};
                  ret_ff <= ST_VX1;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               mul_req_ff.start <= 1'b0;
               if (mul_rsp.done) state_ff <= ret_ff;
            end
            ST_VX1: begin
               t1_ff <= p64;
               mul_req_ff <= '{1'b1, MUL_A_W'(mag_x), MUL_B_W'(mag_x)};
               ret_ff <= ST_VX2;
               state_ff <= ST_MUL;
            end
            ST_VX2: begin
               vx_ff <= vy_in;
               mul_req_ff <= '{1'b1, MUL_A_W'(head.sum_model_sq), MUL_B_W'(head.count)};
               ret_ff <= ST_VY1;
               state_ff <= ST_MUL;
            end
            ST_VY1: begin
               t1_ff <= p64;
               mul_req_ff <= '{1'b1, MUL_A_W'(head.sum_model), MUL_B_W'(head.sum_model)};
               ret_ff <= ST_VY2;
               state_ff <= ST_MUL;
            end
            ST_VY2: begin
               vy_ff <= vy_in;
               if (vx_ff == 64'd0 || vy_in == 64'd0) begin
                  q_ff <= '0;
                  null_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  null_ff <= 1'b0;
                  mul_req_ff <= '{1'b1, MUL_A_W'(mag_xy), MUL_B_W'(head.count)};
                  ret_ff <= ST_CV1;
                  state_ff <= ST_MUL;
               end
            end
            ST_CV1: begin
               t1_ff <= p64;
               mul_req_ff <= '{1'b1, MUL_A_W'(mag_x), MUL_B_W'(head.sum_model)};
               ret_ff <= ST_CV2;
               state_ff <= ST_MUL;
            end
            ST_CV2: begin
               // covariance sign follows sum_cross against sum_trace
               if (head.sum_cross[40] != head.sum_trace[31]) cv_ff <= t1_ff + p64;
               else if (t1_ff >= p64) cv_ff <= t1_ff - p64;
               else cv_ff <= p64 - t1_ff;
               mul_req_ff <= '{1'b1, MUL_A_W'(vx_ff), vy_ff};
               ret_ff <= ST_PROD;
               state_ff <= ST_MUL;
            end
            ST_PROD: begin
               prod_ff <= mul_rsp.p[127:0];
               mul_req_ff <= '{1'b1, MUL_A_W'(cv_ff), cv_ff};
               ret_ff <= ST_LIM;
               state_ff <= ST_MUL;
            end
            ST_LIM: begin
               lim_ff <= mul_rsp.p << 30;
               q_ff <= '0;
               bit_ff <= Q_W'(1) << (Q_W - 1);
               state_ff <= ST_CAND;
            end
            ST_CAND: begin
               if (cand > Q_W'(Q_ONE)) begin
                  bit_ff <= bit_ff >> 1;
                  if (bit_ff[0]) state_ff <= ST_DONE;
               end else begin
                  mul_req_ff <= '{1'b1, MUL_A_W'(cand), MUL_B_W'(cand)};
                  ret_ff <= ST_CSQ;
                  state_ff <= ST_MUL;
               end
            end
            ST_CSQ: begin
               mul_req_ff <= '{1'b1, MUL_A_W'(prod_ff), p64};
               ret_ff <= ST_TEST;
               state_ff <= ST_MUL;
            end
            ST_TEST: begin
               if (mul_rsp.p <= lim_ff) q_ff <= cand;
               bit_ff <= bit_ff >> 1;
               state_ff <= bit_ff[0] ? ST_DONE : ST_CAND;
            end
            ST_DONE: begin
               if (!(rsp_valid_ff && rsp_stall)) begin
                  abs_ff <= q_ff[15:0];
                  nv_ff <= null_ff;
                  used_ff <= head.count;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `PCA_ASSERT(a_rsp_from_pop, clock, reset, $rose(rsp_valid_ff) |-> $past(pop),
      "result without queue pop")
   `PCA_ASSERT(a_mul_in_wait, clock, reset, mul_rsp.done |-> state_ff == ST_MUL,
      "multiply finished outside wait")
endmodule
`default_nettype wire

[rtl/pearson_correlation_accumulator.sv]
// top level of the streaming pearson correlation accumulator
// Items are accepted one per cycle while req_stall is low: the front adds each
// (trace, model) pair to the count and five exact sums in the cycle it is accepted, up
// to 65536 traces. A checkpoint item pushes a snapshot of the sums into a two-entry
// queue; req_stall rises while that queue is full. The back end works out |r| from a
// snapshot with one shared shift-and-add multiplier: eight products for the variance and
// covariance terms and up to two per quotient bit. Null variance results finish after
// four products.
`default_nettype none
module pearson_correlation_accumulator
   import pca_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [15:0]   req_trace_value,
   input  wire logic [7:0]    req_model_value,
   input  wire logic          req_restart,
   input  wire logic          req_checkpoint,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [15:0]        rsp_abs_correlation,
   output logic               rsp_null_variance,
   output logic [COUNT_W-1:0] rsp_traces_used
);
   sums_type push_data, head;
   logic push, pop, full, empty;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   pca_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_trace_value, .req_model_value,
      .req_restart, .req_checkpoint, .queue_full(full), .push, .push_data
   );

   pca_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .head, .full, .empty
   );

   pca_mul u_mul (
      .clock, .reset, .req(mul_req), .rsp(mul_rsp)
   );

   pca_back u_back (
      .clock, .reset, .head, .empty, .pop, .mul_req, .mul_rsp, .rsp_valid, .rsp_stall,
      .rsp_abs_correlation, .rsp_null_variance, .rsp_traces_used
   );
endmodule
`default_nettype wire

[sim/tb_pearson_correlation_accumulator.sv]
// self-checking testbench of the streaming pearson correlation accumulator
`default_nettype none
module tb_pearson_correlation_accumulator
   import pca_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] trace_value;
      logic [7:0]  model_value;
      logic        restart;
      logic        checkpoint;
      bit          drain_first;
   } sample_type;

   typedef struct {
      logic [15:0]        abs_correlation;
      logic               null_variance;
      logic [COUNT_W-1:0] traces_used;
   } corr_type;

   localparam int CYCLE_LIMIT = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [15:0]        req_trace_value = '0;
   logic [7:0]         req_model_value = '0;
   logic               req_restart = 1'b0;
   logic               req_checkpoint = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_abs_correlation;
   logic               rsp_null_variance;
   logic [COUNT_W-1:0] rsp_traces_used;

   sample_type pending_samples[$];
   corr_type   expected_corr[$];
   int         mismatches = 0;
   int         cycle = 0;

   // predictor state
   int     n_traces = 0;
   longint acc_trace = 0, acc_model = 0, acc_trace_sq = 0, acc_model_sq = 0, acc_cross = 0;

   pearson_correlation_accumulator dut (.*);

   always #10 clock = ~clock;

   function automatic corr_type correlation_of_sums();
      corr_type r;
      logic signed [255:0] n, sx, sy, sxx, syy, sxy, vx, vy, cv, prod, lim, c2, t;
      int q, c;
      n = n_traces; sx = acc_trace; sy = acc_model;
      sxx = acc_trace_sq; syy = acc_model_sq; sxy = acc_cross;
      vx = n * sxx - sx * sx;
      vy = n * syy - sy * sy;
      r.traces_used = n_traces[COUNT_W-1:0];
      if (vx <= 0 || vy <= 0) begin
         r.abs_correlation = '0;
         r.null_variance = 1'b1;
         return r;
      end
      cv = n * sxy - sx * sy;
      if (cv < 0) cv = -cv;
      prod = vx * vy;
      lim = (cv * cv) <<< 30;
      q = 0;
      for (int b = 16; b >= 0; b--) begin
         c = q | (1 << b);
         if (c <= Q_ONE) begin
            c2 = c * c;
            t = c2 * prod;
            if (t <= lim) q = c;
         end
      end
      r.abs_correlation = q[15:0];
      r.null_variance = 1'b0;
      return r;
   endfunction

   task automatic accumulate_sample(input sample_type s);
      longint x, y;
      x = longint'($signed(s.trace_value));
      y = longint'(s.model_value);
      if (s.restart) begin
         n_traces = 0; acc_trace = 0; acc_model = 0;
         acc_trace_sq = 0; acc_model_sq = 0; acc_cross = 0;
      end
      if (n_traces < MAX_TRACES) begin
         n_traces++;
         acc_trace += x; acc_model += y;
         acc_trace_sq += x * x; acc_model_sq += y * y; acc_cross += x * y;
      end
      if (s.checkpoint) expected_corr.push_back(correlation_of_sums());
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
      mismatches++;
   endtask

   function automatic bit idle_now();
      if (cycle > 20000 && cycle < 26000) return 1'b0;
      return $urandom_range(99) < 15;
   endfunction

   always @(posedge clock) cycle <= cycle + 1;

   always @(posedge clock) begin
      if (cycle > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            s.trace_value = req_trace_value; s.model_value = req_model_value;
            s.restart = req_restart; s.checkpoint = req_checkpoint; s.drain_first = 1'b0;
            accumulate_sample(s);
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() == 0 || idle_now() ||
                (pending_samples[0].drain_first && expected_corr.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               s = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_trace_value <= s.trace_value;
               req_model_value <= s.model_value;
               req_restart <= s.restart;
               req_checkpoint <= s.checkpoint;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      corr_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_corr.size() == 0) begin
               report_mismatch("unexpected transfer, traces_used", rsp_traces_used, 0);
            end else begin
               want = expected_corr.pop_front();
               if (rsp_abs_correlation !== want.abs_correlation)
                  report_mismatch("abs_correlation", rsp_abs_correlation, want.abs_correlation);
               if (rsp_null_variance !== want.null_variance)
                  report_mismatch("null_variance", rsp_null_variance, want.null_variance);
               if (rsp_traces_used !== want.traces_used)
                  report_mismatch("traces_used", rsp_traces_used, want.traces_used);
            end
         end
         rsp_stall <= idle_now();
      end
   end

   task automatic queue_sample(input int x, input int y, input bit rs, input bit cp,
                               input bit drain = 1'b0);
      sample_type s;
      s.trace_value = x[15:0]; s.model_value = y[7:0];
      s.restart = rs; s.checkpoint = cp; s.drain_first = drain;
      pending_samples.push_back(s);
   endtask

   initial begin
      int len, mode, slope, offs, x, y;
      // extremes, two points always give full correlation
      queue_sample(-32768, 0, 1, 1);
      queue_sample(32767, 255, 0, 1);
      queue_sample(0, 128, 0, 1);
      // nearly perfect negative correlation over three points
      queue_sample(-32768, 255, 1, 0);
      queue_sample(32767, 0, 0, 0);
      queue_sample(0, 127, 0, 1);
      // null variance: constant trace, then constant model
      queue_sample(1234, 3, 1, 0);
      queue_sample(1234, 200, 0, 0);
      queue_sample(1234, 77, 0, 1);
      queue_sample(-5, 9, 1, 0);
      queue_sample(300, 9, 0, 1, 1);
      queue_sample(32767, 255, 1, 1);
      // restart with a checkpoint on a single trace
      queue_sample(-1, 1, 1, 1);
      // random sequences
      for (int i = 0; i < 600; i += len) begin
         len = $urandom_range(40, 2);
         mode = $urandom_range(9);
         slope = $urandom_range(200) - 100;
         offs = $urandom_range(65535) - 32768;
         for (int k = 0; k < len; k++) begin
            y = $urandom_range(255);
            if (mode < 4) x = $urandom_range(65535) - 32768;
            else if (mode < 8) x = offs + slope * y + $urandom_range(2000) - 1000;
            else if (mode == 8) x = offs;
            else begin x = $urandom_range(65535) - 32768; y = slope & 8'hff; end
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            queue_sample(x, y, (k == 0) && ($urandom_range(9) != 0),
                         (k == len - 1) || ($urandom_range(19) == 0),
                         (k == 0) && ($urandom_range(29) == 0));
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_samples.size() != 0 || req_valid) @(posedge clock);
      while (expected_corr.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (mismatches == 0 && expected_corr.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/pca_pkg.sv
rtl/pca_front.sv
rtl/pca_queue.sv
rtl/pca_mul.sv
rtl/pca_back.sv
rtl/pearson_correlation_accumulator.sv
sim/tb_pearson_correlation_accumulator.sv
